FILE: hdl/itoa_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII block.
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned NDIG_W     = 4;
    localparam int unsigned BCD_W      = 4;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 8'h2D;
    // ceil(2^35 / 10): floor(x * DIV10_RECIP / 2^35) == x / 10 for any 32-bit x
    localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int unsigned        DIV10_SHIFT = 35;

    // classified request: sign and unsigned magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } itoa_req_t;

    // converted request: digits least significant first
    typedef struct packed {
        logic                             neg;
        logic [NDIG_W-1:0]                ndig;
        logic [MAX_DIGITS-1:0][BCD_W-1:0] digits;
    } itoa_dig_t;

endpackage

FILE: hdl/itoa_front.sv
// Front stage: accepts integers and splits them into sign and magnitude.
`timescale 1ns / 1ps

module itoa_front
    import itoa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      value_valid,
    output logic                      value_ready,
    output logic                      req_valid,
    input  logic                      req_ready,
    output itoa_req_t                 req
);

    logic      valid_reg;
    logic      valid_next;
    itoa_req_t req_reg;
    itoa_req_t req_next;
    logic      take;

    assign value_ready = !valid_reg || req_ready;
    assign take        = value_valid && value_ready;

    always_comb
    begin
        req_next = req_reg;
        if (take)
        begin
            req_next.neg = value[VALUE_W-1];
            req_next.mag = value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(value))
                                            : $unsigned(value);
        end
        if (take)
            valid_next = 1'b1;
        else if (req_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

FILE: hdl/itoa_fifo.sv
// Short request queue between the front stage and the converter.
`timescale 1ns / 1ps

module itoa_fifo
    import itoa_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  itoa_req_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output itoa_req_t rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    itoa_req_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: hdl/itoa_conv.sv
// Converter: peels one decimal digit per cycle off the magnitude.
`timescale 1ns / 1ps

module itoa_conv
    import itoa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  itoa_req_t req,
    output logic      dig_valid,
    input  logic      dig_ready,
    output itoa_dig_t dig
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } state_t;

    localparam logic [NDIG_W-1:0] LAST_DIGIT = NDIG_W'(MAX_DIGITS - 1);

    state_t               state_reg;
    state_t               state_next;
    logic [VALUE_W-1:0]   mag_reg;
    logic [VALUE_W-1:0]   mag_next;
    itoa_dig_t            dig_reg;
    itoa_dig_t            dig_next;
    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   rem_full;

    assign prod     = mag_reg * DIV10_RECIP;
    assign quot     = VALUE_W'(prod >> DIV10_SHIFT);
    assign rem_full = mag_reg - ((quot << 3) + (quot << 1));

    assign req_ready = (state_reg == S_IDLE);
    assign dig_valid = (state_reg == S_HOLD);
    assign dig       = dig_reg;

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        dig_next   = dig_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mag_next      = req.mag;
                    dig_next.neg  = req.neg;
                    dig_next.ndig = '0;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                dig_next.digits[dig_reg.ndig] = rem_full[BCD_W-1:0];
                dig_next.ndig                 = dig_reg.ndig + NDIG_W'(1);
                mag_next                      = quot;
                if (quot == '0 || dig_reg.ndig == LAST_DIGIT)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (dig_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        dig_reg <= dig_next;
    end

endmodule

FILE: hdl/itoa_emit.sv
// Emitter: sends sign and digits most significant first through an output register.
`timescale 1ns / 1ps

module itoa_emit
    import itoa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dig_valid,
    output logic              dig_ready,
    input  itoa_dig_t         dig,
    output logic [CHAR_W-1:0] character,
    output logic              last,
    output logic              char_valid,
    input  logic              char_ready
);

    logic                             busy_reg;
    logic                             busy_next;
    logic                             sign_reg;
    logic                             sign_next;
    logic [NDIG_W-1:0]                pos_reg;
    logic [NDIG_W-1:0]                pos_next;
    logic [MAX_DIGITS-1:0][BCD_W-1:0] digits_reg;
    logic [MAX_DIGITS-1:0][BCD_W-1:0] digits_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [CHAR_W-1:0]                char_reg;
    logic [CHAR_W-1:0]                char_next;
    logic                             last_reg;
    logic                             last_next;
    logic                             slot_free;
    logic                             produce;
    logic                             finishing;
    logic                             take;

    assign slot_free = !out_valid_reg || char_ready;
    assign produce   = busy_reg && slot_free;
    assign finishing = produce && !sign_reg && (pos_reg == '0);
    assign dig_ready = !busy_reg || finishing;
    assign take      = dig_valid && dig_ready;

    always_comb
    begin
        busy_next      = busy_reg;
        sign_next      = sign_reg;
        pos_next       = pos_reg;
        digits_next    = digits_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (char_ready)
            out_valid_next = 1'b0;
        if (produce)
        begin
            out_valid_next = 1'b1;
            if (sign_reg)
            begin
                char_next = CHAR_MINUS;
                last_next = 1'b0;
                sign_next = 1'b0;
            end
            else
            begin
                char_next = CHAR_ZERO + CHAR_W'(digits_reg[pos_reg]);
                last_next = (pos_reg == '0);
                if (pos_reg == '0)
                    busy_next = 1'b0;
                else
                    pos_next = pos_reg - NDIG_W'(1);
            end
        end
        if (take)
        begin
            busy_next   = 1'b1;
            sign_next   = dig.neg;
            pos_next    = dig.ndig - NDIG_W'(1);
            digits_next = dig.digits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sign_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            sign_reg      <= sign_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign character  = char_reg;
    assign last       = last_reg;
    assign char_valid = out_valid_reg;

endmodule

FILE: hdl/signed_int_to_decimal_ascii_core.sv
// Top level: signed 32-bit integer to decimal ASCII text converter.
//
// Input channel (value, value_valid, value_ready): one request per signed
// 32-bit integer. Output channel (character, last, char_valid, char_ready):
// the number's text, one ASCII character per request, most significant
// first, '-' ahead of negative numbers, last set on the final character.
// Zero gives "0"; the most negative value gives "-2147483648".
// A request is registered in the front stage, queued (QUEUE_DEPTH entries),
// converted at one digit per cycle by a multiply-by-reciprocal divider, and
// handed to the emitter, which drives one character per cycle from its
// output register while the receiver is ready. The converter works on the
// next number while the emitter sends the text of the current one.
// Reset empties the queue and drops any text in progress.
// When the receiver stalls, the emitter holds its character, the converter
// holds its finished digits, and the queue and front stage fill before
// value_ready falls.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core
    import itoa_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      value_valid,
    output logic                      value_ready,
    output logic [CHAR_W-1:0]         character,
    output logic                      last,
    output logic                      char_valid,
    input  logic                      char_ready
);

    logic      front_valid;
    logic      front_ready;
    itoa_req_t front_req;
    logic      q_valid;
    logic      q_ready;
    itoa_req_t q_req;
    logic      dig_valid;
    logic      dig_ready;
    itoa_dig_t dig;

    itoa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .req_valid   (front_valid),
        .req_ready   (front_ready),
        .req         (front_req)
    );

    itoa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_req),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_req)
    );

    itoa_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (q_valid),
        .req_ready (q_ready),
        .req       (q_req),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .dig       (dig)
    );

    itoa_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .dig_valid  (dig_valid),
        .dig_ready  (dig_ready),
        .dig        (dig),
        .character  (character),
        .last       (last),
        .char_valid (char_valid),
        .char_ready (char_ready)
    );

endmodule

FILE: test/tb_top.sv
// Testbench for signed_int_to_decimal_ascii_core: predicts each number's text and checks it.
`timescale 1ns / 1ps

module tb_top;
    import itoa_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned PHASE_ITEMS = 160;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    class ascii_text_board;
        text_char_t  pending_chars[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_request(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] mag;
            logic [3:0]         digits[$];
            text_char_t         c;
            mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
            do
            begin
                digits.push_front(4'(mag % 10));
                mag = mag / 10;
            end
            while (mag != 0);
            if (v[VALUE_W-1])
            begin
                c.ch   = CHAR_MINUS;
                c.last = 1'b0;
                pending_chars.push_back(c);
            end
            foreach (digits[i])
            begin
                c.ch   = CHAR_ZERO + CHAR_W'(digits[i]);
                c.last = (i == digits.size() - 1);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic lst);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected char 0x%02h last %0b", $realtime, ch, lst);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (want.ch !== ch || want.last !== lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected char 0x%02h last %0b, got 0x%02h last %0b",
                                 $realtime, want.ch, want.last, ch, lst);
                end
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      value_valid = 1'b0;
    logic                      value_ready;
    logic [CHAR_W-1:0]         character;
    logic                      last;
    logic                      char_valid;
    logic                      char_ready = 1'b0;

    int unsigned     tx_idle_pct = 24;
    int unsigned     rx_idle_pct = 83;
    int unsigned     hold_cycles = 0;
    int unsigned     quiet_cycles = 0;
    ascii_text_board board = new();

    signed_int_to_decimal_ascii_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .character   (character),
        .last        (last),
        .char_valid  (char_valid),
        .char_ready  (char_ready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            char_ready  <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            char_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
            board.check_char(character, last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (value_valid && value_ready) || (char_valid && char_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_value(input logic [VALUE_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            value_valid <= 1'b0;
            @(negedge clk);
        end
        value       <= v;
        value_valid <= 1'b1;
        do
            @(posedge clk);
        while (!value_ready);
        board.note_request(v);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned        p10[10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                        10000000, 100000000, 1000000000};
        logic [VALUE_W-1:0] m;
        int unsigned        nd;
        nd = $urandom_range(1, 9);
        case ($urandom_range(0, 4))
            0: m = $urandom();
            1: m = $urandom_range(0, 99);
            2: m = $urandom_range(p10[nd - 1], p10[nd] - 1);
            3: m = p10[nd] + $urandom_range(0, 2) - 1;
            default: m = $urandom_range(32'h7FFF_FFFF, 32'h7000_0000);
        endcase
        if ($urandom_range(0, 1) == 1)
            m = ~m + 1'b1;
        return m;
    endfunction

    task automatic send_random(input int unsigned n);
        repeat (n)
            send_value(pick_value());
    endtask

    task automatic drain_text();
        @(negedge clk);
        value_valid <= 1'b0;
        while (board.pending_chars.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [VALUE_W-1:0] directed_vals[] = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, -32'sd100,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
            32'd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
            32'd12345, -32'sd12345, 32'd1000000001, -32'sd1, 32'd4000000000
        };
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_vals[i])
            send_value(directed_vals[i]);
        send_random(PHASE_ITEMS);
        drain_text();

        tx_idle_pct = 83;
        rx_idle_pct = 24;
        send_random(PHASE_ITEMS);
        drain_text();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_cycles = 300;
        send_random(PHASE_ITEMS);
        drain_text();

        repeat (40) @(posedge clk);
        if (board.mismatches == 0 && board.pending_chars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
